[hdl/best_fit_block_allocator_core_assert.svh]
// Assertion macros used by the allocator checker.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BFBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BFBA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

[hdl/bfba_pkg.sv]
// Types and constants shared by the best-fit block allocator files.
package bfba_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int SIZE_BITS  = 16;

    localparam int SIZE_W  = 16;
    localparam int INDEX_W = 5;
    localparam int FRAG_W  = 14;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = ((SIZE_BITS > FRAG_W) ? SIZE_BITS : FRAG_W) + 1;

    localparam logic [FRAG_W-1:0] FRAG_LIMIT = FRAG_W'(10000);

    typedef enum logic
    {
        REQ_LOAD  = 1'b0,
        REQ_ALLOC = 1'b1
    } req_kind_t;

    typedef enum logic [1:0]
    {
        STATUS_ALLOC  = 2'd0,
        STATUS_NOFIT  = 2'd1,
        STATUS_LOADED = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } bfba_state_t;

    typedef struct packed
    {
        req_kind_t         req_type;
        logic [SIZE_W-1:0] size;
    } bfba_req_t;

    typedef struct packed
    {
        status_t            status;
        logic [INDEX_W-1:0] block_index;
        logic [FRAG_W-1:0]  fragment;
    } bfba_rsp_t;

endpackage

[hdl/best_fit_block_allocator_core.sv]
// Best-fit block allocator: block size table, used marks and the scan sequencer.
// Load request: the result passes through ST_FINISH into the output register, and ready returns as it appears.
// Allocate request: one compare per table entry, made in turn from entry 0, since the single
// table read port and the shared subtract/compare unit serve one entry at a time.
// One request in flight at a time.
// Reset (rst_n low, asynchronous) clears the used marks, the block count and control.
module best_fit_block_allocator_core
    import bfba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  bfba_req_t item,
    output logic      result_valid,
    input  logic      result_ready,
    output bfba_rsp_t result
);

    // Block size table; entries at or above the count are never read by the scan.
    logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic                 mem_we;

    // Control state.
    bfba_state_t      state_reg,     state_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [MAX_BLOCKS-1:0] used_reg, used_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             found_reg,     found_next;
    logic             out_valid_reg, out_valid_next;

    // Scan datapath and result staging.
    logic [IDX_W-1:0]     addr_reg,     addr_next;
    logic [IDX_W-1:0]     cmp_idx_reg,  cmp_idx_next;
    logic [IDX_W-1:0]     pick_reg,     pick_next;
    logic [FRAG_W-1:0]    best_reg,     best_next;
    logic [SIZE_BITS-1:0] req_size_reg, req_size_next;
    bfba_rsp_t            res_reg,      res_next;
    bfba_rsp_t            out_reg,      out_next;

    // Shared subtract/compare unit: leftover of the entry read last cycle.
    logic [CMP_W-1:0] diff_w;
    logic             fits_w;

    assign diff_w = CMP_W'(rd_data_reg) - CMP_W'(req_size_reg);
    assign fits_w = cmp_valid_reg && !used_reg[cmp_idx_reg] && !diff_w[CMP_W-1]
                    && (diff_w < CMP_W'(best_reg));

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        cmp_valid_next = 1'b0;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !result_ready;
        addr_next      = addr_reg;
        cmp_idx_next   = addr_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        req_size_next  = req_size_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;

        // Fold the compare result into the running best; strict less keeps the lowest index.
        if (fits_w)
        begin
            best_next  = diff_w[FRAG_W-1:0];
            pick_next  = cmp_idx_reg;
            found_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    res_next.block_index = '0;
                    res_next.fragment    = '0;
                    if (item.req_type == REQ_LOAD)
                    begin
                        if (count_reg == CNT_W'(MAX_BLOCKS))
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            // Append the block size at the next free slot.
                            mem_we               = 1'b1;
                            res_next.status      = STATUS_LOADED;
                            res_next.block_index = INDEX_W'(count_reg);
                            count_next           = count_reg + CNT_W'(1);
                        end
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        req_size_next = SIZE_BITS'(item.size);
                        addr_next     = '0;
                        best_next     = FRAG_LIMIT;
                        pick_next     = '0;
                        found_next    = 1'b0;
                        if (count_reg == '0)
                        begin
                            // Empty table: nothing to scan.
                            res_next.status = STATUS_NOFIT;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one table read per cycle; its compare runs the cycle after.
                cmp_valid_next = 1'b1;
                if (CNT_W'(addr_reg) == count_reg - CNT_W'(1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end

            ST_LAST:
            begin
                // Last compare is folded this cycle; build the result from the next values.
                if (found_next)
                begin
                    used_next[pick_next] = 1'b1;
                    res_next.status      = STATUS_ALLOC;
                    res_next.block_index = INDEX_W'(pick_next);
                    res_next.fragment    = best_next;
                end
                else
                begin
                    res_next.status      = STATUS_NOFIT;
                    res_next.block_index = '0;
                    res_next.fragment    = '0;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || result_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            used_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        cmp_idx_reg  <= cmp_idx_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        req_size_reg <= req_size_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[count_reg[IDX_W-1:0]] <= SIZE_BITS'(item.size);
        end
        rd_data_reg <= size_mem[addr_reg];
    end

endmodule

[hdl/bfba_checker.sv]
// Port-level checker for the best-fit block allocator and its bind.
`include "best_fit_block_allocator_core_assert.svh"

module bfba_checker
    import bfba_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_ready,
    input bfba_req_t item,
    input logic      result_valid,
    input logic      result_ready,
    input bfba_rsp_t result
);

    logic fail_w;
    logic zero_w;

    assign fail_w = (result.status == STATUS_NOFIT) || (result.status == STATUS_FULL);
    assign zero_w = (result.block_index == '0) && (result.fragment == '0);

    `BFBA_ASSERT_NXT(a_busy_after_accept, item_valid && item_ready, !item_ready)
    `BFBA_ASSERT_IMP(a_frag_below_limit, result_valid, result.fragment < FRAG_LIMIT)
    `BFBA_ASSERT_IMP(a_fail_is_zero, result_valid && fail_w, zero_w)
    `BFBA_ASSERT_NXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind best_fit_block_allocator_core bfba_checker u_bfba_checker (.*);
